@@ rtl/srf_pkg.sv @@
// Shared types for the signal range fold unit.
package srf_pkg;

  // How the final stage forms the result.
  typedef enum logic [1:0] {
    MODE_LO    = 2'd0,  // equal bounds
    MODE_PASS  = 2'd1,  // sample already within bounds
    MODE_BELOW = 2'd2,  // sample under the low bound
    MODE_ABOVE = 2'd3   // sample over the high bound
  } mode_e;

endpackage

@@ rtl/signal_range_fold_unit.sv @@
// Reflecting wavefolder: folds each sample back into its own [low, high] range.
//
// Input stream s_axis carries one sample and two bounds per beat; output
// stream m_axis carries the folded sample. All values are signed fixed point
// of DATA_WIDTH bits; the fraction width does not change the arithmetic.
// Reversed bounds are swapped, equal bounds give low, a sample within the
// bounds passes through unchanged.
//
// From input beat to output beat a sample passes the input register, bound
// ordering, range and distance, one restoring-divider stage per bit of the
// distance, then the result adder into the output register. Throughput is
// one beat per cycle while not stalled, set by the fully pipelined divider.
//
// Reset clears all valid bits; no results are pending afterwards.
// When the receiver stalls, one result is parked in a skid register and the
// pipeline advances once more; after that the pipeline holds and s_axis_tready
// drops until the parked beat is taken. Nothing is lost or repeated.
module signal_range_fold_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_in, bound_a, bound_b (lowest bits first), zero padded to bytes
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // folded_out, zero padded to bytes
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata
);
  import srf_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  logic adv;

  // input register
  logic         v0_q;
  logic [W-1:0] s0_q, a0_q, b0_q;

  // ordered bounds
  logic         v1_q;
  logic [W-1:0] s1_q, lo1_q, hi1_q;

  // divider pipeline, index 0 loaded by the range / distance stage
  logic         dv_q    [0:W];
  logic [W-1:0] dsmp_q  [0:W];
  logic [W-1:0] dlo_q   [0:W];
  logic [W-1:0] dhi_q   [0:W];
  logic [W-1:0] drng_q  [0:W];
  logic [W-1:0] ddiv_q  [0:W];
  logic [W-1:0] drem_q  [0:W];
  logic         dqb_q   [0:W];
  mode_e        dmode_q [0:W];

  // output and skid
  logic         vo_q, skid_v_q;
  logic [W-1:0] res_q, skid_q;
  logic [W-1:0] res_d;

  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = skid_v_q | vo_q;
  assign m_axis_tdata  = OUT_W'(skid_v_q ? skid_q : res_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      dv_q[0]  <= 1'b0;
      vo_q     <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v0_q    <= s_axis_tvalid;
        v1_q    <= v0_q;
        dv_q[0] <= v1_q;
        vo_q    <= dv_q[W];
        if (vo_q && !m_axis_tready) begin
          skid_v_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  // front stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s_axis_tdata[W-1:0];
      a0_q <= s_axis_tdata[2*W-1:W];
      b0_q <= s_axis_tdata[3*W-1:2*W];

      s1_q <= s0_q;
      if ($signed(a0_q) > $signed(b0_q)) begin
        lo1_q <= b0_q;
        hi1_q <= a0_q;
      end else begin
        lo1_q <= a0_q;
        hi1_q <= b0_q;
      end

      dsmp_q[0] <= s1_q;
      dlo_q[0]  <= lo1_q;
      dhi_q[0]  <= hi1_q;
      drng_q[0] <= hi1_q - lo1_q;
      drem_q[0] <= '0;
      dqb_q[0]  <= 1'b0;
      if (lo1_q == hi1_q) begin
        dmode_q[0] <= MODE_LO;
        ddiv_q[0]  <= '0;
      end else if ($signed(s1_q) < $signed(lo1_q)) begin
        dmode_q[0] <= MODE_BELOW;
        ddiv_q[0]  <= lo1_q - s1_q;
      end else if ($signed(s1_q) > $signed(hi1_q)) begin
        dmode_q[0] <= MODE_ABOVE;
        ddiv_q[0]  <= s1_q - hi1_q;
      end else begin
        dmode_q[0] <= MODE_PASS;
        ddiv_q[0]  <= '0;
      end
    end
  end

  // restoring divider: one quotient bit per stage, distance bits enter MSB first
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W:0]   trial;
    logic [W-1:0] rem_d;
    logic         qb_d;

    always_comb begin
      trial = {drem_q[k-1], ddiv_q[k-1][W-1]};
      if (trial >= {1'b0, drng_q[k-1]}) begin
        rem_d = W'(trial - {1'b0, drng_q[k-1]});
        qb_d  = 1'b1;
      end else begin
        rem_d = trial[W-1:0];
        qb_d  = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (adv) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dsmp_q[k]  <= dsmp_q[k-1];
        dlo_q[k]   <= dlo_q[k-1];
        dhi_q[k]   <= dhi_q[k-1];
        drng_q[k]  <= drng_q[k-1];
        dmode_q[k] <= dmode_q[k-1];
        ddiv_q[k]  <= {ddiv_q[k-1][W-2:0], 1'b0};
        drem_q[k]  <= rem_d;
        dqb_q[k]   <= qb_d;
      end
    end
  end

  // parity of the quotient picks which bound the remainder counts from
  always_comb begin
    unique case (dmode_q[W])
      MODE_LO:    res_d = dlo_q[W];
      MODE_PASS:  res_d = dsmp_q[W];
      MODE_BELOW: res_d = dqb_q[W] ? dhi_q[W] - drem_q[W] : dlo_q[W] + drem_q[W];
      MODE_ABOVE: res_d = dqb_q[W] ? dlo_q[W] + drem_q[W] : dhi_q[W] - drem_q[W];
      default:    res_d = dlo_q[W];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      if (vo_q && !m_axis_tready) begin
        skid_q <= res_q;
      end
    end
  end

endmodule

@@ test/tb_signal_range_fold_unit.sv @@
// Testbench for signal_range_fold_unit: directed and random streams checked against a fold predictor.
`timescale 1ns / 1ps

module tb_signal_range_fold_unit;

  localparam int DW         = 32;
  localparam int TAIL_WAIT  = 80;    // cycles after the last result
  localparam int STALL_MAX  = 2000;  // cycles without any beat before giving up
  localparam int HOLD_LEN   = 300;   // long receiver hold-off
  localparam int HOLD_AT    = 600;   // results seen before the hold-off starts
  localparam int RAND_ITEMS = 1530;

  localparam logic [DW-1:0] MAXV = 32'h7fff_ffff;
  localparam logic [DW-1:0] MINV = 32'h8000_0000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;

  logic [95:0]   pending_beats[$];
  logic [DW-1:0] expected_folds[$];

  bit in_beat, out_beat, held_off, stalled;
  int n_items, n_accepted, n_checked, mismatches, quiet_cycles, hold_cnt;
  bit calm;

  signal_range_fold_unit #(.DATA_WIDTH(DW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reflect s into [lo, hi]; parity of the fold count picks the bound the remainder counts from.
  function automatic logic [DW-1:0] fold_sample(logic signed [DW-1:0] s,
                                                logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    longint lo, hi, sv, span, excess, folds, rem, res;
    sv = longint'(s);
    lo = longint'((a > b) ? b : a);
    hi = longint'((a > b) ? a : b);
    if (lo == hi) begin
      res = lo;
    end else if (sv >= lo && sv <= hi) begin
      res = sv;
    end else begin
      span   = hi - lo;
      excess = (sv < lo) ? lo - sv : sv - hi;
      folds  = excess / span;
      rem    = excess - folds * span;
      if (sv < lo) begin
        res = (folds % 2 == 0) ? lo + rem : hi - rem;
      end else begin
        res = (folds % 2 == 0) ? hi - rem : lo + rem;
      end
    end
    return res[DW-1:0];
  endfunction

  task automatic add_item(logic [DW-1:0] s, logic [DW-1:0] a, logic [DW-1:0] b);
    pending_beats.push_back({b, a, s});
  endtask

  // Sender: a new beat only once the previous one has gone.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_beat)) begin
      if (pending_beats.size() == 0 || (!calm && $urandom_range(0, 99) < 37)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off so the pipeline fills.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (!held_off && n_checked >= HOLD_AT) begin
        held_off      <= 1'b1;
        hold_cnt      <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Monitor, scoreboard and watchdog.
  always @(posedge clk_i) begin
    in_beat  = s_axis_tvalid && s_axis_tready;
    out_beat = m_axis_tvalid && m_axis_tready;
    if (out_beat) begin
      if (expected_folds.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        logic [DW-1:0] want;
        want = expected_folds.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: folded_out mismatch, expected %h, got %h", $time, want, m_axis_tdata);
          mismatches++;
        end
      end
      n_checked++;
    end
    if (in_beat) begin
      expected_folds.push_back(fold_sample(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                           s_axis_tdata[95:64]));
      n_accepted++;
    end
    calm = (n_accepted >= 700 && n_accepted < 950);
    if (in_beat || out_beat || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) stalled = 1'b1;
    end
  end

  initial begin
    logic [DW-1:0] s, a, b;
    longint lo, hi;
    int kind;

    // directed: passing, reversed, equal bounds, each fold parity, exact multiples, extremes
    add_item(32'd0, -32'sd65536, 32'sd65536);
    add_item(32'd0, 32'sd65536, -32'sd65536);
    add_item(32'd123456, 32'd5, 32'd5);
    add_item(-32'sd50, 32'd0, 32'd100);
    add_item(-32'sd150, 32'd0, 32'd100);
    add_item(-32'sd200, 32'd0, 32'd100);
    add_item(-32'sd100, 32'd0, 32'd100);
    add_item(32'd250, 32'd100, 32'd0);
    add_item(32'd200, 32'd0, 32'd100);
    add_item(32'd300, 32'd0, 32'd100);
    add_item(32'd150, 32'd0, 32'd100);
    add_item(MINV, MAXV, MINV);
    add_item(MAXV, MINV, MAXV);
    add_item(MINV, MAXV, MAXV - 1);
    add_item(MAXV, MINV, MINV + 1);
    add_item(MINV, 32'd0, 32'd0);
    add_item(MAXV, MAXV, MAXV);
    add_item(MINV, -32'sd1, MAXV);
    add_item(MAXV, MINV, 32'd0);
    add_item(MINV, MAXV, 32'd0);
    add_item(-32'sd1, 32'd0, 32'd1);
    add_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffe);

    repeat (RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      s = $urandom();
      a = $urandom();
      b = $urandom();
      case (kind)
        2, 3, 4: begin
          // narrow range, many folds
          b = a + $urandom_range(1, 1000);
          if (kind == 4) s = a + $urandom_range(0, 20000) - 10000;
        end
        5, 6: begin
          lo = longint'((signed'(a) > signed'(b)) ? signed'(b) : signed'(a));
          hi = longint'((signed'(a) > signed'(b)) ? signed'(a) : signed'(b));
          s = DW'(lo + (longint'($urandom()) % (hi - lo + 1)));
        end
        7: begin
          b = a;
        end
        8: begin
          s = (($urandom_range(0, 1) != 0) ? a : b) + $urandom_range(0, 6) - 3;
        end
        default: ;
      endcase
      add_item(s, a, b);
    end
    n_items = pending_beats.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      begin
        wait (n_accepted == n_items && n_checked == n_items);
        repeat (TAIL_WAIT) @(posedge clk_i);
      end
      wait (stalled);
    join_any

    if (stalled || mismatches != 0) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule
